// ----- hw/rtl/msfrx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msfrx_pkg
// Shared constants, types and functions of the sensor frame receiver.
// ----------------------------------------------------------------------------
package msfrx_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int CRC_SPAN  = 7;
    localparam int CNT_W     = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam logic [7:0]  FUNC_CODE  = 8'h03;
    localparam logic [7:0]  BYTE_COUNT = 8'h04;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef struct packed {
        logic load;
        logic step;
    } t_crc_ctl;

    // fold one byte into the reflected CRC-16, one bit per inner step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // negative words map to word minus 65535, i.e. word plus one mod 2^16
    function automatic logic [15:0] temp_conv(input logic [7:0] hi,
                                              input logic [7:0] lo);
        logic [15:0] w;
        w = {hi, lo};
        if (hi[7]) begin
            return w + 16'd1;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/modbus_sensor_frame_rx_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_sensor_frame_rx_top
// Sliding nine-byte window receiver for Modbus temperature/humidity replies.
// ----------------------------------------------------------------------------
// Each received byte is one request. While fewer than eight bytes are held,
// a byte is simply stored. Once the window is full, each byte starts a
// check: the CRC unit folds the seven oldest window bytes one byte per cycle,
// then the check state compares sync bytes and CRC; the next byte is not
// accepted until the check ends. An accepted frame loads the output register
// and empties the window; if an earlier result is still waiting, the check
// holds until the output register is free.
module modbus_sensor_frame_rx_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata    // [7:0] slave_addr,
                                          // [23:8] temperature_tenths,
                                          // [39:24] humidity_tenths
);
    import msfrx_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CRC   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_win [WIN_DEPTH];
    logic [7:0]        n_win [WIN_DEPTH];
    logic [7:0]        r_new, n_new;
    logic              r_out_valid, n_out_valid;
    logic [39:0]       r_out, n_out;

    t_crc_ctl    crc_ctl;
    logic [15:0] crc;
    logic        s_acc;
    logic        frame_ok;
    logic        out_free;

    msfrx_crc u_crc (
        .i_clk   (i_clk),
        .i_ctl   (crc_ctl),
        .i_digit (r_win[r_cnt]),
        .o_crc   (crc)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign frame_ok   = (r_win[1] == FUNC_CODE) && (r_win[2] == BYTE_COUNT) &&
                        (r_win[7] == crc[7:0]) && (r_new == crc[15:8]);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_win       = r_win;
        n_new       = r_new;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        crc_ctl     = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (r_fill < FILL_W'(WIN_DEPTH)) begin
                        n_win[r_fill[CNT_W-1:0]] = i_s_tdata;
                        n_fill = r_fill + FILL_W'(1);
                    end else begin
                        n_new        = i_s_tdata;
                        n_cnt        = '0;
                        crc_ctl.load = 1'b1;
                        n_state      = S_CRC;
                    end
                end
            end
            S_CRC: begin
                crc_ctl.step = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CRC_SPAN - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (frame_ok) begin
                    if (out_free) begin
                        n_out       = {r_win[5], r_win[6], temp_conv(r_win[3], r_win[4]),
                                       r_win[0]};
                        n_out_valid = 1'b1;
                        for (int i = 0; i < WIN_DEPTH; i++) begin
                            n_win[i] = '0;
                        end
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[WIN_DEPTH-1] = r_new;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_win       <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule
`default_nettype wire

// ----- hw/rtl/msfrx_crc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msfrx_crc
// Byte-serial CRC-16 accumulator: one window byte folded per step.
// ----------------------------------------------------------------------------
module msfrx_crc (
    input  wire logic                i_clk,
    input  wire msfrx_pkg::t_crc_ctl i_ctl,
    input  wire logic [7:0]          i_digit,
    output logic [15:0]              o_crc
);
    import msfrx_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.load) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.step) begin
            n_crc = crc_byte(r_crc, i_digit);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule
`default_nettype wire

// ----- hw/rtl/msfrx_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msfrx_checker
// Port-level checks of the sensor frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module msfrx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [7:0]  i_s_tdata,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready && (i_s_tdata == i_s_tdata);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[23:8] != 16'h8000))
        else $error("temperature out of range");

    a_check_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> (!$past(s_acc, 1) && !$past(s_acc, 2)))
        else $error("result too soon after request");

endmodule

bind modbus_sensor_frame_rx_top msfrx_checker u_msfrx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Modbus sensor frame receiver.
// ----------------------------------------------------------------------------
// Streams received bytes into the block. The bytes are mostly well-formed
// sensor reply frames with random content, mixed with noise bytes and
// frames that have one flipped bit. A local copy of the nine-byte window
// predicts each decoded reading. Every request the block takes updates that
// copy. Readings from the block are checked field by field, oldest first.
// The sender and the receiver idle and stall at different rates in each
// phase, and the bench waits for all readings between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import msfrx_pkg::*;

    typedef struct packed {
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic [7:0]  addr;
    } t_sensor_reading;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;            // [7:0] slave_addr, [23:8] temperature_tenths,
                                       // [39:24] humidity_tenths

    logic [7:0]      rx_byte_queue[$];
    t_sensor_reading expected_readings[$];
    logic [7:0]      frame_window[0:7];
    logic [3:0]      frame_fill;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              mismatch_count;

    modbus_sensor_frame_rx_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc_in,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        repeat (8) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("tb_top: mismatch %s: got %h, expected %h", what, got, exp_val);
        mismatch_count++;
    endtask

    // update the local window with one accepted byte; queue a reading on a good frame
    task automatic decode_byte(input logic [7:0] b);
        logic [15:0]     crc;
        logic [15:0]     tword;
        t_sensor_reading rd;
        if (frame_fill < 4'd8) begin
            frame_window[frame_fill[2:0]] = b;
            frame_fill = frame_fill + 4'd1;
        end else begin
            crc = CRC_INIT;
            for (int i = 0; i < 7; i++) begin
                crc = modbus_crc_byte(crc, frame_window[i]);
            end
            if (frame_window[1] == FUNC_CODE && frame_window[2] == BYTE_COUNT &&
                frame_window[7] == crc[7:0] && b == crc[15:8]) begin
                tword = {frame_window[3], frame_window[4]};
                rd.addr        = frame_window[0];
                rd.temperature = tword[15] ? tword + 16'd1 : tword;
                rd.humidity    = {frame_window[5], frame_window[6]};
                expected_readings.push_back(rd);
                for (int i = 0; i < 8; i++) begin
                    frame_window[i] = 8'h00;
                end
                frame_fill = 4'd0;
            end else begin
                for (int i = 0; i < 7; i++) begin
                    frame_window[i] = frame_window[i + 1];
                end
                frame_window[7] = b;
            end
        end
    endtask

    task automatic check_reading(input logic [39:0] data);
        t_sensor_reading got;
        t_sensor_reading exp_rd;
        got = data;
        if (expected_readings.size() == 0) begin
            report_mismatch("unexpected reading, addr", {8'h00, got.addr}, 16'h0000);
        end else begin
            exp_rd = expected_readings.pop_front();
            if (got.addr != exp_rd.addr) begin
                report_mismatch("slave_addr", {8'h00, got.addr}, {8'h00, exp_rd.addr});
            end
            if (got.temperature != exp_rd.temperature) begin
                report_mismatch("temperature_tenths", got.temperature, exp_rd.temperature);
            end
            if (got.humidity != exp_rd.humidity) begin
                report_mismatch("humidity_tenths", got.humidity, exp_rd.humidity);
            end
        end
    endtask

    // build one reply frame; corrupt_pos >= 0 flips one bit of that byte
    task automatic add_frame(input logic [7:0] addr, input logic [15:0] tword,
                             input logic [15:0] hum, input int corrupt_pos);
        logic [7:0]  fb[0:8];
        logic [15:0] crc;
        int          bit_sel;
        fb[0] = addr;
        fb[1] = FUNC_CODE;
        fb[2] = BYTE_COUNT;
        fb[3] = tword[15:8];
        fb[4] = tword[7:0];
        fb[5] = hum[15:8];
        fb[6] = hum[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 7; i++) begin
            crc = modbus_crc_byte(crc, fb[i]);
        end
        fb[7] = crc[7:0];
        fb[8] = crc[15:8];
        if (corrupt_pos >= 0) begin
            bit_sel = $urandom_range(7);
            fb[corrupt_pos][bit_sel] = ~fb[corrupt_pos][bit_sel];
        end
        for (int i = 0; i < 9; i++) begin
            rx_byte_queue.push_back(fb[i]);
        end
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        while ((rx_byte_queue.size() != 0 || i_s_tvalid || expected_readings.size() != 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    // driver: predict on each accepted request, then present the next byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'h00;
            for (int i = 0; i < 8; i++) begin
                frame_window[i] = 8'h00;
            end
            frame_fill = 4'd0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (rx_byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= rx_byte_queue.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each delivered reading, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_reading(o_m_tdata);
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int          count;
        int          kind;
        int          noise_len;
        int          tsel;
        logic [15:0] tword;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of each field, negative zero, lowest temperature, bad sync
        add_frame(8'hFF, 16'hFFFF, 16'h0000, -1);
        add_frame(8'h00, 16'h8000, 16'hFFFF, -1);
        add_frame(8'h5A, 16'h7FFF, 16'h1234, 2);
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 77; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 77; end
                default: begin send_idle_pct = 37; recv_idle_pct = 37; end
            endcase
            count = 0;
            while (count < 165) begin
                kind = $urandom_range(99);
                if (kind < 15) begin
                    noise_len = $urandom_range(1, 6);
                    repeat (noise_len) rx_byte_queue.push_back(8'($urandom_range(255)));
                    count += noise_len;
                end else begin
                    tsel = $urandom_range(9);
                    case (tsel)
                        0: tword = 16'hFFFF;
                        1: tword = 16'h8000;
                        2: tword = 16'h7FFF;
                        3: tword = 16'h0000;
                        default: tword = 16'($urandom_range(65535));
                    endcase
                    add_frame(8'($urandom_range(255)), tword, 16'($urandom_range(65535)),
                              (kind < 30) ? int'($urandom_range(8)) : -1);
                    count += 9;
                end
            end
            wait_drain();
        end

        if (expected_readings.size() != 0) begin
            report_mismatch("readings never delivered", 16'(expected_readings.size()),
                            16'h0000);
        end
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
